// File: rtl/csop_pkg.sv
package csop_pkg;

	// Header opcodes, taken from bits 31:28 of a header word.
	localparam logic [3:0] OP_SETCL   = 4'd0;
	localparam logic [3:0] OP_INCR    = 4'd1;
	localparam logic [3:0] OP_NONINCR = 4'd2;
	localparam logic [3:0] OP_MASK    = 4'd3;
	localparam logic [3:0] OP_IMM     = 4'd4;
	localparam logic [3:0] OP_RESTART = 4'd5;
	localparam logic [3:0] OP_GATHER  = 4'd6;
	localparam logic [3:0] OP_EXTEND  = 4'd14;

	// Word kinds.
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Insert modes of a GATHER header.
	localparam logic [1:0] GATHER_NONE    = 2'd0;
	localparam logic [1:0] GATHER_NONINCR = 2'd1;
	localparam logic [1:0] GATHER_INCR    = 2'd2;

	// Parser state carried from one word to the next.
	typedef struct packed {
		logic        expect_payload;
		logic [3:0]  owner_opcode;
		logic [11:0] base_offset;
		logic [15:0] remaining_mask;
		logic [15:0] remaining_count;
		logic [15:0] payload_index;
	} parse_state_t;

	// One decoded result.
	typedef struct packed {
		logic        word_kind;
		logic [3:0]  opcode;
		logic [11:0] offset_field;
		logic [9:0]  class_id;
		logic [15:0] short_value;
		logic [1:0]  gather_mode;
		logic [3:0]  extend_subop;
		logic [23:0] extend_value;
		logic [31:0] restart_address;
		logic [16:0] register_address;
		logic [31:0] payload_data;
	} result_t;

endpackage

// File: rtl/csop_decode.sv
module csop_decode (
	input  logic [31:0]           word,
	input  logic                  last,
	input  csop_pkg::parse_state_t st,
	output csop_pkg::parse_state_t nxt,
	output csop_pkg::result_t     res
);
	import csop_pkg::*;

	logic [3:0]  low_idx;
	logic [3:0]  op;
	logic [11:0] off;

	assign op  = word[31:28];
	assign off = word[27:16];

	// Index of the lowest mask bit still to be served.
	always_comb begin
		low_idx = 4'd0;
		for (int i = 15; i >= 0; i--) begin
			if (st.remaining_mask[i]) begin
				low_idx = 4'(i);
			end
		end
	end

	always_comb begin
		logic done;
		done = 1'b0;
		res  = '0;
		nxt  = st;
		if (st.expect_payload) begin
			res.word_kind        = KIND_PAYLOAD;
			res.opcode           = st.owner_opcode;
			res.offset_field     = st.base_offset;
			res.payload_data     = word;
			res.register_address = {5'd0, st.base_offset};
			if (st.owner_opcode == OP_SETCL || st.owner_opcode == OP_MASK) begin
				res.register_address = {5'd0, st.base_offset} + {13'd0, low_idx};
				nxt.remaining_mask = st.remaining_mask & ~(16'd1 << low_idx);
				done = (nxt.remaining_mask == 16'd0);
			end else begin
				if (st.owner_opcode == OP_INCR) begin
					res.register_address = {5'd0, st.base_offset} + {1'b0, st.payload_index};
					nxt.payload_index = st.payload_index + 16'd1;
				end
				nxt.remaining_count = st.remaining_count - 16'd1;
				done = (nxt.remaining_count == 16'd0);
			end
			if (done) begin
				nxt.expect_payload = 1'b0;
			end
		end else begin
			res.word_kind       = KIND_HEADER;
			res.opcode          = op;
			nxt.owner_opcode    = op;
			nxt.base_offset     = off;
			nxt.remaining_mask  = 16'd0;
			nxt.remaining_count = 16'd0;
			nxt.payload_index   = 16'd0;
			nxt.expect_payload  = 1'b0;
			case (op)
				OP_SETCL: begin
					res.offset_field   = off;
					res.class_id       = word[15:6];
					res.short_value    = {10'd0, word[5:0]};
					nxt.remaining_mask = {10'd0, word[5:0]};
					nxt.expect_payload = (word[5:0] != 6'd0);
				end
				OP_MASK: begin
					res.offset_field   = off;
					res.short_value    = word[15:0];
					nxt.remaining_mask = word[15:0];
					nxt.expect_payload = (word[15:0] != 16'd0);
				end
				OP_INCR, OP_NONINCR: begin
					res.offset_field    = off;
					res.short_value     = word[15:0];
					nxt.remaining_count = word[15:0];
					nxt.expect_payload  = (word[15:0] != 16'd0);
				end
				OP_IMM: begin
					res.offset_field = off;
					res.short_value  = word[15:0];
				end
				OP_RESTART: begin
					res.restart_address = {word[27:0], 4'd0};
				end
				OP_GATHER: begin
					res.offset_field = off;
					res.short_value  = {2'd0, word[13:0]};
					if (word[15]) begin
						res.gather_mode = word[14] ? GATHER_INCR : GATHER_NONINCR;
					end else begin
						res.gather_mode = GATHER_NONE;
					end
					nxt.remaining_count = 16'd1;
					nxt.expect_payload  = 1'b1;
				end
				OP_EXTEND: begin
					res.extend_subop = word[27:24];
					res.extend_value = word[23:0];
				end
				default: begin
					nxt.base_offset = 12'd0;
				end
			endcase
		end
		if (last) begin
			nxt.expect_payload = 1'b0;
		end
	end

endmodule

// File: rtl/csop_out_queue.sv
module csop_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csop_pkg::result_t push_data,
	output logic              full,
	output logic              pop_valid,
	input  logic              pop_ready,
	output csop_pkg::result_t pop_data
);
	import csop_pkg::*;

	result_t    entry_q [2];
	logic       head_q;
	logic [1:0] count_q;
	logic       tail;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign tail      = head_q ^ count_q[0];
	assign pop_data  = entry_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (pop) begin
				head_q <= ~head_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("push without pop did not grow the queue");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 2'd1)
		else $error("pop without push did not shrink the queue");
`endif

endmodule

// File: rtl/command_stream_opcode_parser.sv
// Command stream opcode parser.
//
// The input channel (in_valid / in_ready) takes one 32-bit command word per
// request, together with end_of_buffer, which marks the last word of a buffer.
// Every accepted word yields exactly one result request on the output channel
// (out_valid / out_ready): the word is reported as a header with its decoded
// fields, or as a payload word with the opcode of its header and the register
// address that it targets.
//
// A word is captured in the input stage at acceptance, decoded against the
// parser state, and its result is registered into a two-entry result queue
// that drives the output ports. Throughput is one word per cycle while the
// queue has room, set by the single decode pass that also updates the state.
// When the receiver stalls, the queue absorbs up to two results and the input
// stage holds a third word; in_ready falls only once all three are occupied.
//
// Reset empties the input stage and the queue and returns the parser to
// expecting a header, with all state cleared to zero.
module command_stream_opcode_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] command_word,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        word_kind,
	output logic [3:0]  opcode,
	output logic [11:0] offset_field,
	output logic [9:0]  class_id,
	output logic [15:0] short_value,
	output logic [1:0]  gather_mode,
	output logic [3:0]  extend_subop,
	output logic [23:0] extend_value,
	output logic [31:0] restart_address,
	output logic [16:0] register_address,
	output logic [31:0] payload_data
);
	import csop_pkg::*;

	// Input stage: one accepted word waiting for its decode pass.
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        eob_s1;

	// Parser state, updated once per decoded word.
	parse_state_t state_q;
	parse_state_t state_next;
	result_t      dec_result;
	result_t      out_result;

	logic queue_full;
	logic advance;

	// The stage moves on whenever the result queue has room for its result.
	assign advance  = valid_s1 && !queue_full;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= command_word;
			eob_s1  <= end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_next;
			end
		end
	end

	csop_decode u_decode (
		.word (word_s1),
		.last (eob_s1),
		.st   (state_q),
		.nxt  (state_next),
		.res  (dec_result)
	);

	csop_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (dec_result),
		.full      (queue_full),
		.pop_valid (out_valid),
		.pop_ready (out_ready),
		.pop_data  (out_result)
	);

	assign word_kind        = out_result.word_kind;
	assign opcode           = out_result.opcode;
	assign offset_field     = out_result.offset_field;
	assign class_id         = out_result.class_id;
	assign short_value      = out_result.short_value;
	assign gather_mode      = out_result.gather_mode;
	assign extend_subop     = out_result.extend_subop;
	assign extend_value     = out_result.extend_value;
	assign restart_address  = out_result.restart_address;
	assign register_address = out_result.register_address;
	assign payload_data     = out_result.payload_data;

`ifndef SYNTHESIS
	a_mask_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.expect_payload &&
		 (state_q.owner_opcode == OP_SETCL || state_q.owner_opcode == OP_MASK))
		|-> state_q.remaining_mask != 16'd0)
		else $error("payload expected with an empty mask");
	a_count_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.expect_payload &&
		 (state_q.owner_opcode == OP_INCR || state_q.owner_opcode == OP_NONINCR ||
		  state_q.owner_opcode == OP_GATHER))
		|-> state_q.remaining_count != 16'd0)
		else $error("payload expected with a zero count");
	a_eob_header: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eob_s1) |=> !state_q.expect_payload)
		else $error("parser still expects payload after end of buffer");
`endif

endmodule
